>>> hdl/efp_pkg.sv
// shared types, constants and register codes for the escaped packet framer
package efp_pkg;

    localparam int DEF_MAX_PAYLOAD_BYTES = 8;
    localparam int QUEUE_DEPTH           = 2;
    localparam int HDR_BYTES             = 6;
    localparam int CFG_ADDR_W            = 4;
    localparam int CFG_DATA_W            = 32;
    localparam int SIZE_W                = 4;

    localparam logic [7:0] SOF_VALUE_RST   = 8'd126;
    localparam logic [7:0] ESC_VALUE_RST   = 8'd125;
    localparam logic [7:0] ESCAPE_MASK_RST = 8'd32;

    localparam logic [1:0] REG_SOF_VALUE   = 2'd0;
    localparam logic [1:0] REG_ESC_VALUE   = 2'd1;
    localparam logic [1:0] REG_ESCAPE_MASK = 2'd2;

    typedef struct packed {
        logic [7:0] sof_value;
        logic [7:0] esc_value;
        logic [7:0] escape_mask;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REJECT,
        ST_START,
        ST_DATA,
        ST_ESCAPED,
        ST_CHECKSUM
    } efp_state_t;

endpackage

>>> hdl/efp_regs.sv
// configuration register file behind the apb port
module efp_regs
    import efp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_SOF_VALUE:   cfg_next.sof_value   = pwdata[7:0];
                REG_ESC_VALUE:   cfg_next.esc_value   = pwdata[7:0];
                REG_ESCAPE_MASK: cfg_next.escape_mask = pwdata[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SOF_VALUE:   prdata = {24'd0, cfg_reg.sof_value};
            REG_ESC_VALUE:   prdata = {24'd0, cfg_reg.esc_value};
            REG_ESCAPE_MASK: prdata = {24'd0, cfg_reg.escape_mask};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sof_value   <= SOF_VALUE_RST;
            cfg_reg.esc_value   <= ESC_VALUE_RST;
            cfg_reg.escape_mask <= ESCAPE_MASK_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hdl/efp_front.sv
// record classifier: reject check and payload alignment into a queue entry
module efp_front
    import efp_pkg::*;
#(
    parameter int MAX_PAYLOAD_BYTES = DEF_MAX_PAYLOAD_BYTES,
    parameter int PW = 8 * MAX_PAYLOAD_BYTES,
    parameter int DW = 48 + PW,
    parameter int CW = $clog2(HDR_BYTES + MAX_PAYLOAD_BYTES + 1),
    parameter int EW = 1 + DW + CW
)
(
    input  logic [31:0]       timestamp,
    input  logic [15:0]       msg_id,
    input  logic [63:0]       payload,
    input  logic [SIZE_W-1:0] payload_size,
    input  logic              type_supported,
    output logic [EW-1:0]     entry
);

    logic              reject;
    logic [SIZE_W-1:0] gap;
    logic [PW-1:0]     pl_aligned;
    logic [CW-1:0]     byte_cnt;

    assign reject     = !type_supported || (payload_size > SIZE_W'(MAX_PAYLOAD_BYTES));
    assign gap        = SIZE_W'(MAX_PAYLOAD_BYTES) - payload_size;
    assign pl_aligned = payload[PW-1:0] << {gap, 3'b000};
    assign byte_cnt   = CW'(payload_size) + CW'(HDR_BYTES);
    assign entry      = {reject, timestamp, msg_id, pl_aligned, byte_cnt};

endmodule

>>> hdl/efp_queue.sv
// short item queue between classifier and serializer
module efp_queue
    import efp_pkg::*;
#(
    parameter int EW    = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [EW-1:0] wr_data,
    output logic          full,
    input  logic          pop,
    output logic [EW-1:0] rd_data,
    output logic          not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [EW-1:0]    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hdl/efp_back.sv
// frame serializer: SOF, stuffed data, checksum, one byte per cycle unless stalled
module efp_back
    import efp_pkg::*;
#(
    parameter int MAX_PAYLOAD_BYTES = DEF_MAX_PAYLOAD_BYTES,
    parameter int PW = 8 * MAX_PAYLOAD_BYTES,
    parameter int DW = 48 + PW,
    parameter int CW = $clog2(HDR_BYTES + MAX_PAYLOAD_BYTES + 1),
    parameter int EW = 1 + DW + CW
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          q_not_empty,
    input  logic [EW-1:0] q_data,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          last_byte,
    output logic          rejected
);

    efp_state_t    state_reg;
    efp_state_t    state_next;
    logic [DW-1:0] data_reg;
    logic [DW-1:0] data_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [7:0]    sum_reg;
    logic [7:0]    sum_next;
    logic [7:0]    pend_reg;
    logic [7:0]    pend_next;
    logic          final_reg;
    logic          final_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [7:0]    out_byte_reg;
    logic [7:0]    out_byte_next;
    logic          last_reg;
    logic          last_next;
    logic          rej_reg;
    logic          rej_next;

    logic          adv;
    logic          q_reject;
    logic [7:0]    cur_byte;
    logic          cur_special;
    logic          sum_special;

    assign adv         = !out_valid_reg || out_ready;
    assign q_reject    = q_data[EW-1];
    assign cur_byte    = data_reg[DW-1 -: 8];
    assign cur_special = (cur_byte == cfg.sof_value) || (cur_byte == cfg.esc_value);
    assign sum_special = (sum_reg == cfg.sof_value) || (sum_reg == cfg.esc_value);

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = last_reg;
    assign rejected  = rej_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    state_next = q_reject ? ST_REJECT : ST_START;
                end
            end
            ST_REJECT:
            begin
                if (adv)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_START:
            begin
                if (adv)
                begin
                    state_next = ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (adv)
                begin
                    if (cur_special)
                    begin
                        state_next = ST_ESCAPED;
                    end
                    else if (cnt_reg == CW'(1))
                    begin
                        state_next = ST_CHECKSUM;
                    end
                end
            end
            ST_ESCAPED:
            begin
                if (adv)
                begin
                    if (final_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (cnt_reg == '0)
                    begin
                        state_next = ST_CHECKSUM;
                    end
                    else
                    begin
                        state_next = ST_DATA;
                    end
                end
            end
            ST_CHECKSUM:
            begin
                if (adv)
                begin
                    state_next = sum_special ? ST_ESCAPED : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and output register
    always_comb
    begin
        q_pop          = 1'b0;
        data_next      = data_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        pend_next      = pend_reg;
        final_next     = final_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        rej_next       = rej_reg;
        if (adv)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop      = 1'b1;
                    data_next  = q_data[CW +: DW];
                    cnt_next   = q_data[CW-1:0];
                    final_next = 1'b0;
                end
            end
            ST_REJECT:
            begin
                if (adv)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = 8'd0;
                    last_next      = 1'b1;
                    rej_next       = 1'b1;
                end
            end
            ST_START:
            begin
                if (adv)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = cfg.sof_value;
                    last_next      = 1'b0;
                    rej_next       = 1'b0;
                    sum_next       = cfg.sof_value;
                end
            end
            ST_DATA:
            begin
                if (adv)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b0;
                    rej_next       = 1'b0;
                    sum_next       = sum_reg + cur_byte;
                    data_next      = data_reg << 8;
                    cnt_next       = cnt_reg - 1'b1;
                    if (cur_special)
                    begin
                        out_byte_next = cfg.esc_value;
                        pend_next     = cur_byte ^ cfg.escape_mask;
                        final_next    = 1'b0;
                    end
                    else
                    begin
                        out_byte_next = cur_byte;
                    end
                end
            end
            ST_ESCAPED:
            begin
                if (adv)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = pend_reg;
                    last_next      = final_reg;
                    rej_next       = 1'b0;
                end
            end
            ST_CHECKSUM:
            begin
                if (adv)
                begin
                    out_valid_next = 1'b1;
                    rej_next       = 1'b0;
                    if (sum_special)
                    begin
                        out_byte_next = cfg.esc_value;
                        last_next     = 1'b0;
                        pend_next     = sum_reg ^ cfg.escape_mask;
                        final_next    = 1'b1;
                    end
                    else
                    begin
                        out_byte_next = sum_reg;
                        last_next     = 1'b1;
                    end
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg     <= data_next;
        cnt_reg      <= cnt_next;
        sum_reg      <= sum_next;
        pend_reg     <= pend_next;
        final_reg    <= final_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        rej_reg      <= rej_next;
    end

endmodule

>>> hdl/escaped_packet_framer.sv
// top level of the escaped packet framer
//
//   channel   direction  handshake                  payload
//   in        input      in_valid / in_ready        timestamp msg_id payload payload_size
//                                                   type_supported
//   out       output     out_valid / out_ready      out_byte last_byte rejected
//   apb       input      psel penable pwrite pready paddr pwdata prdata
//
// a frame leaves the serializer output register one byte per cycle unless out_ready stalls
// a record is 8 + payload_size bytes after its queue pickup, up to 31 with escapes
// a rejected record gives one zero byte with rejected and last_byte set
// the two-entry queue takes items until full while the serializer is stalled by out_ready
// reset clears queue and serializer control; registers return to 126, 125, 32
module escaped_packet_framer
    import efp_pkg::*;
#(
    parameter int MAX_PAYLOAD_BYTES = DEF_MAX_PAYLOAD_BYTES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [31:0]           timestamp,
    input  logic [15:0]           msg_id,
    input  logic [63:0]           payload,
    input  logic [SIZE_W-1:0]     payload_size,
    input  logic                  type_supported,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  last_byte,
    output logic                  rejected,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int PW = 8 * MAX_PAYLOAD_BYTES;
    localparam int DW = 48 + PW;
    localparam int CW = $clog2(HDR_BYTES + MAX_PAYLOAD_BYTES + 1);
    localparam int EW = 1 + DW + CW;

    cfg_t          cfg;
    logic [EW-1:0] entry;
    logic [EW-1:0] q_data;
    logic          q_full;
    logic          q_not_empty;
    logic          q_pop;
    logic          push;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    efp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    efp_front #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES),
        .PW                (PW),
        .DW                (DW),
        .CW                (CW),
        .EW                (EW)
    ) u_front (
        .timestamp      (timestamp),
        .msg_id         (msg_id),
        .payload        (payload),
        .payload_size   (payload_size),
        .type_supported (type_supported),
        .entry          (entry)
    );

    efp_queue #(
        .EW    (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   (entry),
        .full      (q_full),
        .pop       (q_pop),
        .rd_data   (q_data),
        .not_empty (q_not_empty)
    );

    efp_back #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES),
        .PW                (PW),
        .DW                (DW),
        .CW                (CW),
        .EW                (EW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_not_empty (q_not_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_byte   (last_byte),
        .rejected    (rejected)
    );

endmodule

>>> hdl/efp_checker.sv
// port-level checks on the framer output stream, bound to the top level
module efp_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       last_byte,
    input logic       rejected
);

    // stalled output item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(last_byte) && $stable(rejected))
        else $error("output item changed while stalled");

    // a refused record is a single item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> last_byte)
        else $error("rejected item without last_byte");

    // a refused record carries a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> out_byte == 8'd0)
        else $error("rejected item with nonzero byte");

    // no gap inside a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_byte |=> out_valid && !rejected)
        else $error("bubble inside a frame");

endmodule

bind escaped_packet_framer efp_checker u_checker (.*);
